FILE: hw/rtl/sql_keyword_stripper_defines.svh
// Assertion macros shared by the keyword stripper checker.
`ifndef SQL_KEYWORD_STRIPPER_DEFINES_SVH
`define SQL_KEYWORD_STRIPPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SKW_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyword stripper check failed");

// Next-cycle implication, disabled while reset is high.
`define SKW_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyword stripper check failed");

`endif

FILE: hw/rtl/skw_pkg.sv
// Package with the keyword table, item types and helper functions of the keyword stripper.
`timescale 1ns / 1ps
`default_nettype none

package skw_pkg;

  localparam int KW_ROWS   = 16;
  localparam int KW_MAXLEN = 6;
  localparam int KW_LEN_W  = 3;

  // Keyword text, first character in the top byte, padded with zero bytes.
  localparam logic [KW_MAXLEN*8-1:0] KW_TEXT [KW_ROWS] = '{
    "SELECT",
    "INSERT",
    "UPDATE",
    "DELETE",
    {"UNION", 8'h00},
    {"DROP", 16'h0000},
    "CONCAT",
    "PRAGMA",
    {"1=1", 24'h000000},
    {"SLEEP", 8'h00},
    48'h0, 48'h0, 48'h0, 48'h0, 48'h0, 48'h0
  };

  localparam logic [KW_LEN_W-1:0] KW_LEN [KW_ROWS] = '{
    3'd6, 3'd6, 3'd6, 3'd6, 3'd5, 3'd4, 3'd6, 3'd6, 3'd3, 3'd5,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
  };

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       has_char;
    logic       end_of_result;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef enum logic {
    ST_STREAM,
    ST_DRAIN
  } skw_state_t;

  // Only A-Z fold to lower case; every other byte compares exactly.
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic [7:0] kw_char(input int row, input int pos);
    logic [KW_MAXLEN*8-1:0] text;
    text = KW_TEXT[row];
    return text[(KW_MAXLEN-1-pos)*8 +: 8];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/skw_cell.sv
// One window cell: holds a byte, shifts toward the head and compares against the keyword column.
`timescale 1ns / 1ps
`default_nettype none

module skw_cell #(
  parameter int POS = 0
) (
  input  logic                         clk,
  input  skw_pkg::cell_ctl_t           ctl,
  input  logic [7:0]                   nbr_byte,
  input  logic [7:0]                   in_byte,
  output logic [7:0]                   cell_byte,
  output logic [skw_pkg::KW_ROWS-1:0]  eq
);
  import skw_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cell_byte <= in_byte;
    end else if (ctl.shift) begin
      cell_byte <= nbr_byte;
    end
  end

  generate
    if (POS < KW_MAXLEN) begin : g_cmp
      for (genvar k = 0; k < KW_ROWS; k++) begin : g_kw
        assign eq[k] = (fold(cell_byte) == fold(kw_char(k, POS)));
      end
    end else begin : g_nocmp
      // No keyword reaches this far, so the column always agrees.
      assign eq = '1;
    end
  endgenerate

endmodule

`default_nettype wire

FILE: hw/rtl/skw_match.sv
// Keyword matcher: combines the cell compare columns and picks the first keyword in table order.
`timescale 1ns / 1ps
`default_nettype none

module skw_match #(
  parameter int WINDOW_LEN  = 6,
  parameter int KEYWORD_NUM = 10
) (
  input  logic [skw_pkg::KW_ROWS-1:0]       eq [WINDOW_LEN],
  input  logic [$clog2(WINDOW_LEN+1)-1:0]   avail,
  output logic [skw_pkg::KW_LEN_W-1:0]      match_len
);
  import skw_pkg::*;

  localparam int FILL_W = $clog2(WINDOW_LEN + 1);

  logic [KW_ROWS-1:0] hit_vec;

  generate
    for (genvar k = 0; k < KW_ROWS; k++) begin : g_kw
      if (k < KEYWORD_NUM) begin : g_used
        logic hit;
        always_comb begin
          hit = (KW_LEN[k] != '0) && (FILL_W'(KW_LEN[k]) <= avail);
          for (int i = 0; i < WINDOW_LEN; i++) begin
            if (i < int'(KW_LEN[k]) && !eq[i][k]) begin
              hit = 1'b0;
            end
          end
        end
        assign hit_vec[k] = hit;
      end else begin : g_unused
        assign hit_vec[k] = 1'b0;
      end
    end
  endgenerate

  // Lowest table row wins.
  always_comb begin
    match_len = '0;
    for (int k = KW_ROWS - 1; k >= 0; k--) begin
      if (hit_vec[k]) begin
        match_len = KW_LEN[k];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sql_keyword_stripper.sv
// Top level of the keyword stripper: window cell chain, head decision and result register.
// Usage:
//   Text bytes arrive on the text channel (text_valid / text_ready / text_item), one byte
//   per transfer, with end_of_text set on the last byte of a string. Kept bytes leave on
//   the result channel (result_valid / result_ready / result_item), one per transfer.
//   While a string streams, the block takes one byte every cycle while the receiver
//   keeps up. A byte is decided once the WINDOW_LEN - 1 bytes after it are held; the
//   head decision then runs, and a kept byte is written into the output register.
//   A transfer with end_of_text starts a drain of the window: one head decision per cycle
//   for each byte still held while the receiver keeps up, then the final result is sent.
//   text_ready stays low for the whole drain, and receiver stalls on kept bytes lengthen
//   it. The last byte kept in the drain carries end_of_result; a string whose drain
//   keeps nothing ends with a single result with has_char low.
//   A stalled receiver holds the output register; the chain keeps accepting bytes until
//   the window is full and its head decision needs the output register.
//   Synchronous reset empties the window, clears the skip count and the drain state, and
//   drops any result not yet transferred.
`timescale 1ns / 1ps
`default_nettype none

module sql_keyword_stripper #(
  parameter int WINDOW_LEN  = 6,
  parameter int KEYWORD_NUM = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                text_valid,
  output logic                text_ready,
  input  skw_pkg::in_item_t   text_item,
  output logic                result_valid,
  input  logic                result_ready,
  output skw_pkg::out_item_t  result_item
);
  import skw_pkg::*;

  localparam int FILL_W = $clog2(WINDOW_LEN + 1);

  // Control state.
  skw_state_t          state, state_next;
  logic [FILL_W-1:0]   fill, fill_next;
  logic [KW_LEN_W-1:0] skip, skip_next;
  logic                hold_valid, hold_valid_next;
  logic [7:0]          hold_byte;

  // Cell chain.
  logic [7:0]          cell_bytes [WINDOW_LEN];
  logic [KW_ROWS-1:0]  cell_eq    [WINDOW_LEN];
  logic [KW_LEN_W-1:0] match_len;

  // Decision and handshake terms.
  logic                text_accept;
  logic                out_free;
  logic                emit;
  logic                step_go;
  logic                drain_done;
  logic [FILL_W-1:0]   load_idx;
  logic                push_valid;
  out_item_t           push_item;

  assign text_accept = text_valid && text_ready;
  assign out_free    = !result_valid || result_ready;

  // The head byte is kept when it is not inside a dropped keyword and no keyword starts there.
  assign emit = (skip == '0) && (match_len == '0);

  // The new byte lands in the first free cell after this cycle's shift.
  assign load_idx = fill - FILL_W'(step_go);

  generate
    for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
      cell_ctl_t  ctl;
      logic [7:0] nbr;
      assign ctl.shift = step_go;
      assign ctl.load  = text_accept && (load_idx == FILL_W'(i));
      if (i == WINDOW_LEN - 1) begin : g_tail
        assign nbr = text_item.char_in;
      end else begin : g_body
        assign nbr = cell_bytes[i+1];
      end
      skw_cell #(
        .POS (i)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .nbr_byte  (nbr),
        .in_byte   (text_item.char_in),
        .cell_byte (cell_bytes[i]),
        .eq        (cell_eq[i])
      );
    end
  endgenerate

  // Only keywords that fit in the bytes held from the head onward can match.
  skw_match #(
    .WINDOW_LEN  (WINDOW_LEN),
    .KEYWORD_NUM (KEYWORD_NUM)
  ) u_match (
    .eq        (cell_eq),
    .avail     (fill),
    .match_len (match_len)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_STREAM: begin
        if (text_accept && text_item.end_of_text) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_done) begin
          state_next = ST_STREAM;
        end
      end
      default: state_next = ST_STREAM;
    endcase
  end

  // Decisions and output selection.
  always_comb begin
    step_go    = 1'b0;
    drain_done = 1'b0;
    text_ready = 1'b0;
    push_valid = 1'b0;
    push_item  = '{char_out: cell_bytes[0], has_char: 1'b1, end_of_result: 1'b0};
    hold_valid_next = hold_valid;
    unique case (state)
      ST_STREAM: begin
        // A full window decides its head; a kept byte needs room in the output register.
        step_go    = (fill == FILL_W'(WINDOW_LEN)) && (!emit || out_free);
        text_ready = (fill != FILL_W'(WINDOW_LEN)) || step_go;
        push_valid = step_go && emit;
      end
      ST_DRAIN: begin
        // Kept bytes pass through the hold register so the last one can be marked.
        if (fill != '0) begin
          step_go = !emit || !hold_valid || out_free;
          if (step_go && emit) begin
            push_valid      = hold_valid;
            push_item       = '{char_out: hold_byte, has_char: 1'b1, end_of_result: 1'b0};
            hold_valid_next = 1'b1;
          end
        end else begin
          drain_done = out_free;
          if (drain_done) begin
            push_valid      = 1'b1;
            hold_valid_next = 1'b0;
            if (hold_valid) begin
              push_item = '{char_out: hold_byte, has_char: 1'b1, end_of_result: 1'b1};
            end else begin
              push_item = '{char_out: 8'h00, has_char: 1'b0, end_of_result: 1'b1};
            end
          end
        end
      end
      default: begin
        step_go = 1'b0;
      end
    endcase
  end

  // Window bookkeeping.
  always_comb begin
    fill_next = fill - FILL_W'(step_go) + FILL_W'(text_accept);
    skip_next = skip;
    if (step_go) begin
      if (skip != '0) begin
        skip_next = skip - KW_LEN_W'(1);
      end else if (match_len != '0) begin
        skip_next = match_len - KW_LEN_W'(1);
      end
    end
    if (drain_done) begin
      skip_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_STREAM;
      fill         <= '0;
      skip         <= '0;
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state      <= state_next;
      fill       <= fill_next;
      skip       <= skip_next;
      hold_valid <= hold_valid_next;
      if (push_valid) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (push_valid) begin
      result_item <= push_item;
    end
    if (state == ST_DRAIN && step_go && emit) begin
      hold_byte <= cell_bytes[0];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/skw_checker.sv
// Port-level checker for the keyword stripper and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "sql_keyword_stripper_defines.svh"

module skw_checker (
  input logic                clk,
  input logic                rst,
  input logic                text_valid,
  input logic                text_ready,
  input skw_pkg::in_item_t   text_item,
  input logic                result_valid,
  input logic                result_ready,
  input skw_pkg::out_item_t  result_item
);
  import skw_pkg::*;

  // A stalled result holds its value until it is transferred.
  `SKW_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result_item))

  // A result without a byte only ever closes a string.
  `SKW_ASSERT_NOW(a_empty_is_final, clk, rst, result_valid && !result_item.has_char, result_item.end_of_result)

  // The end of a string starts a drain, during which no new byte is taken.
  `SKW_ASSERT_NEXT(a_drain_blocks, clk, rst, text_valid && text_ready && text_item.end_of_text, !text_ready)

endmodule

bind sql_keyword_stripper skw_checker u_skw_checker (.*);

`default_nettype wire

FILE: test/sql_keyword_stripper_checker.sv
// Checker for the keyword stripper: predicts kept bytes per text transfer and compares results.
`timescale 1ns / 1ps

module sql_keyword_stripper_checker #(
  parameter int WINDOW_LEN = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                text_valid,
  input  logic                text_ready,
  input  skw_pkg::in_item_t   text_item,
  input  logic                result_valid,
  input  logic                result_ready,
  input  skw_pkg::out_item_t  result_item,
  output int                  mismatches,
  output int                  pending,
  output int                  results_seen
);

  localparam int KEYWORDS = 10;

  // Stored lower case, so only the incoming byte needs folding. Order matters: first hit wins.
  string keyword [KEYWORDS] = '{"select", "insert", "update", "delete", "union",
                                "drop", "concat", "pragma", "1=1", "sleep"};

  logic [7:0]         win [WINDOW_LEN];
  int                 win_fill;
  skw_pkg::out_item_t kept_due [$];

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  // Length of the first keyword that starts at the window head and fits in avail bytes.
  function automatic int keyword_at_head(input int avail);
    int  n;
    int  hit_len;
    bit  hit;
    hit_len = 0;
    for (int k = 0; k < KEYWORDS; k++) begin
      n = keyword[k].len();
      if (hit_len == 0 && n <= avail) begin
        hit = 1'b1;
        for (int i = 0; i < n; i++) begin
          if (lower(win[i]) != keyword[k][i]) hit = 1'b0;
        end
        if (hit) hit_len = n;
      end
    end
    return hit_len;
  endfunction

  function automatic void drop_head(input int n);
    for (int i = 0; i < WINDOW_LEN; i++) begin
      win[i] = (i + n < win_fill) ? win[i + n] : 8'h00;
    end
    win_fill -= n;
  endfunction

  // One head decision: either a keyword is cut out, or the head byte is kept.
  function automatic bit take_head();
    skw_pkg::out_item_t r;
    int n;
    n = keyword_at_head(win_fill);
    if (n > 0) begin
      drop_head(n);
      return 1'b0;
    end
    r.char_out = win[0];
    r.has_char = 1'b1;
    r.end_of_result = 1'b0;
    kept_due.push_back(r);
    drop_head(1);
    return 1'b1;
  endfunction

  function automatic void strip_byte(input skw_pkg::in_item_t t);
    skw_pkg::out_item_t r;
    int produced;
    produced = 0;
    win[win_fill] = t.char_in;
    win_fill++;
    if (!t.end_of_text) begin
      while (win_fill >= WINDOW_LEN) begin
        if (take_head()) produced++;
      end
    end else begin
      while (win_fill > 0) begin
        if (take_head()) produced++;
      end
      if (produced == 0) begin
        // Nothing survived: a bare end marker closes the string.
        r = '0;
        r.end_of_result = 1'b1;
        kept_due.push_back(r);
      end else begin
        r = kept_due.pop_back();
        r.end_of_result = 1'b1;
        kept_due.push_back(r);
      end
    end
  endfunction

  always @(posedge clk) begin
    skw_pkg::out_item_t want;
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) win[i] = 8'h00;
      win_fill = 0;
      kept_due.delete();
      mismatches = 0;
      results_seen = 0;
    end else begin
      if (text_valid && text_ready) strip_byte(text_item);
      if (result_valid && result_ready) begin
        results_seen++;
        if (kept_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected nothing, actual char %h has %b end %b",
                   $time, result_item.char_out, result_item.has_char,
                   result_item.end_of_result);
        end else begin
          want = kept_due.pop_front();
          if (result_item.char_out !== want.char_out || result_item.has_char !== want.has_char
              || result_item.end_of_result !== want.end_of_result) begin
            mismatches++;
            $display("%0t: expected char %h has %b end %b, actual char %h has %b end %b",
                     $time, want.char_out, want.has_char, want.end_of_result,
                     result_item.char_out, result_item.has_char, result_item.end_of_result);
          end
        end
      end
    end
    pending = kept_due.size();
  end

endmodule

FILE: test/sql_keyword_stripper_tb.sv
// Testbench top for the keyword stripper: clock, reset, text stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps

module sql_keyword_stripper_tb;

  localparam int WINDOW_LEN  = 6;
  localparam int TEXT_BYTES  = 320;  // stop offering new strings past this many bytes
  localparam int CALM_AFTER  = 260;  // from here on neither side idles
  localparam int HOLD_AT     = 120;  // the long receiver hold-off starts around here
  localparam int LONG_HOLD   = 80;   // cycles the receiver refuses results in one stretch
  // No transfer at all for this many cycles means the block is stuck. The slowest correct
  // stretch is the long hold-off plus a drain and a few stall bursts, far below this.
  localparam int STALL_LIMIT = 1000;
  localparam int VOCAB_N     = 20;

  logic               clk;
  logic               rst;
  logic               text_valid;
  logic               text_ready;
  skw_pkg::in_item_t  text_item;
  logic               result_valid;
  logic               result_ready;
  skw_pkg::out_item_t result_item;

  int mismatches;
  int pending;
  int results_seen;

  // Shared between the sender and the receiver process.
  bit hold_req;
  bit calm;
  int holds_done;

  int         bytes_sent;
  int         strings_sent;
  int         gap_odds;
  logic [7:0] text_buf [$];

  // Keywords mixed with near misses, so that partial matches and overlaps show up often.
  string vocab [VOCAB_N] = '{"select", "insert", "update", "delete", "union", "drop",
                             "concat", "pragma", "1=1", "sleep", "selec", "unio", "dro",
                             "1=", "sleepy", "ununion", "dropdrop", "1=1=1", "inserinsert",
                             "concatenate"};

  sql_keyword_stripper #(
    .WINDOW_LEN (WINDOW_LEN)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text_item    (text_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  sql_keyword_stripper_checker #(
    .WINDOW_LEN (WINDOW_LEN)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text_item    (text_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: any transfer on either channel resets the count of dead cycles.
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (text_valid && text_ready) || (result_valid && result_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("watchdog: no transfer for %0d cycles at %0t", STALL_LIMIT, $time);
    $display("status: fail");
    $finish;
  end

  // Receiver. Stall bursts come at a rate that changes now and then, including stretches
  // with no stalls. One long hold-off is requested by the sender so that the window
  // fills and the block pushes back on text transfers.
  initial begin
    int stall_odds;
    result_ready = 1'b0;
    stall_odds = 0;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 40) == 0) begin
        case ($urandom_range(0, 2))
          0: stall_odds = 0;
          1: stall_odds = 8;
          default: stall_odds = 3;
        endcase
      end
      if (hold_req) begin
        hold_req = 1'b0;
        holds_done++;
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end else begin
        result_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Offers one byte and returns at the falling edge after its transfer. Valid stays high
  // on return, so back-to-back bytes never drop it.
  task automatic offer(input logic [7:0] c, input logic last);
    skw_pkg::in_item_t t;
    t.char_in = c;
    t.end_of_text = last;
    text_item <= t;
    text_valid <= 1'b1;
    @(posedge clk);
    while (!text_ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Sends the whole buffer as one string, with random sender gaps between bytes.
  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) begin
      if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
        text_valid <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      offer(text_buf[i], i == text_buf.size() - 1);
      if (bytes_sent == HOLD_AT) hold_req = 1'b1;
    end
    strings_sent++;
  endtask

  task automatic append(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // Builds a string from random pieces: keywords and near misses in random case, plain
  // filler, fully random bytes, and bytes next to the letter ranges or with the top bit
  // set, which must never fold onto a keyword letter.
  task automatic build_random_text();
    string      w;
    logic [7:0] c;
    int         pieces;
    int         flip;
    text_buf.delete();
    pieces = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
    repeat (pieces) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          w = vocab[$urandom_range(0, VOCAB_N - 1)];
          for (int i = 0; i < w.len(); i++) begin
            c = w[i];
            if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
            text_buf.push_back(c);
          end
        end
        6, 7: begin
          repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(32, 126)));
        end
        8: begin
          // A NUL byte is rare but allowed by the port and must pass through.
          repeat ($urandom_range(1, 4)) begin
            text_buf.push_back(($urandom_range(0, 15) == 0) ? 8'h00
                                                            : 8'($urandom_range(1, 255)));
          end
        end
        default: begin
          w = vocab[$urandom_range(0, VOCAB_N - 1)];
          flip = $urandom_range(0, w.len() - 1);
          for (int i = 0; i < w.len(); i++) begin
            c = w[i];
            if (i == flip) begin
              case ($urandom_range(0, 3))
                0: c = c | 8'h80;
                1: c = 8'h40;
                2: c = 8'h5B;
                default: c = ($urandom_range(0, 1) == 1) ? 8'h60 : 8'h7B;
              endcase
            end
            text_buf.push_back(c);
          end
        end
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    text_valid = 1'b0;
    text_item = '0;
    hold_req = 1'b0;
    calm = 1'b0;
    holds_done = 0;
    bytes_sent = 0;
    strings_sent = 0;
    gap_odds = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. A one-byte string drains at once, and a string that is nothing but
    // a keyword leaves only the bare end marker.
    text_buf.delete();
    append("x");
    send_text();
    text_buf.delete();
    append("1=1");
    send_text();

    // Byte extremes around a mixed-case keyword, and the bytes just outside A-Z and a-z.
    text_buf.delete();
    text_buf.push_back(8'h00);
    append("sElEcT");
    text_buf.push_back(8'hFF);
    text_buf.push_back(8'h80);
    text_buf.push_back(8'h40);
    text_buf.push_back(8'h5B);
    text_buf.push_back(8'h60);
    text_buf.push_back(8'h7B);
    send_text();

    // A near miss that is passed through, followed by a keyword that only fits while
    // the window drains at the end of the string.
    text_buf.delete();
    append("unioDRop");
    send_text();

    // Random part: mostly well-formed text with keywords, with random gaps on both sides.
    while (bytes_sent < TEXT_BYTES) begin
      if (bytes_sent >= CALM_AFTER) calm = 1'b1;
      gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
      build_random_text();
      send_text();
    end
    text_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Run covered %0d strings, %0d text bytes and %0d results, with keywords in mixed",
             strings_sent, bytes_sent, results_seen);
    $display("case, near misses, fold-edge and high bytes, random gaps and %0d long hold-off(s).",
             holds_done);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
